// ===== rtl/glyph_outline_flattener_defines.svh =====
// Assertion macros shared by the glyph outline flattener RTL
`ifndef GLYPH_OUTLINE_FLATTENER_DEFINES_SVH
`define GLYPH_OUTLINE_FLATTENER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define GOF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph outline flattener check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define GOF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph outline flattener check failed");

`endif

// ===== rtl/gof_pkg.sv =====
// Package: widths, codes, control structs and Bernstein weight tables
`default_nettype none

package gof_pkg;

   // Points per curve segment
   localparam int unsigned SAMPLES = 30;
   localparam int unsigned IDX_W   = $clog2(SAMPLES);

   // Field widths
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned RECIP_W    = 24;
   localparam int unsigned POINT_W    = 20;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   // Q1.16 weights, one of them can reach exactly 1.0
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned WEIGHT_W = FRAC_W + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);

   // Opcodes
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd0;
   localparam logic [OP_W-1:0] OP_LINE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUAD  = 2'd2;
   localparam logic [OP_W-1:0] OP_CUBIC = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BEARING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP     = 2'd2;

   localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd8192;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_ISSUE
   } state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic             load;
      logic             issue;
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] index;
      logic             strip_start;
      logic             last;
   } ctrl_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic advance;
   } dp_status_type;

   // Weight table: [sample][control point slot], slot 3 is always the end point
   typedef logic [SAMPLES-1:0][3:0][WEIGHT_W-1:0] weight_table_type;

   localparam longint unsigned SPAN = longint'(SAMPLES - 1);
   localparam longint unsigned DEN2 = SPAN * SPAN;
   localparam longint unsigned DEN3 = SPAN * SPAN * SPAN;

   function automatic longint unsigned ipow(longint unsigned b, int unsigned e);
      longint unsigned r;
      r = 1;
      for (int unsigned j = 0; j < e; j++) begin
         r = r * b;
      end
      return r;
   endfunction

   // Rounded Bernstein weights; elaboration time only
   function automatic weight_table_type build_weights(int unsigned deg);
      weight_table_type tbl;
      longint unsigned  num;
      longint unsigned  c;
      int unsigned      slot;
      tbl = '0;
      for (int unsigned i = 0; i < SAMPLES; i++) begin
         for (int unsigned k = 0; k <= deg; k++) begin
            if (deg == 3 && (k == 1 || k == 2)) begin
               c = 3;
            end else if (deg == 2 && k == 1) begin
               c = 2;
            end else begin
               c = 1;
            end
            num  = c * ipow(longint'(i), k) * ipow(SPAN - longint'(i), deg - k) * 65536;
            slot = (deg == 2 && k == 2) ? 3 : k;
            if (deg == 2) begin
               tbl[i][slot] = WEIGHT_W'((num + DEN2 / 2) / DEN2);
            end else begin
               tbl[i][slot] = WEIGHT_W'((num + DEN3 / 2) / DEN3);
            end
         end
      end
      return tbl;
   endfunction

   localparam weight_table_type QUAD_WEIGHTS  = build_weights(2);
   localparam weight_table_type CUBIC_WEIGHTS = build_weights(3);

endpackage

`default_nettype wire

// ===== rtl/glyph_outline_flattener.sv =====
// Top level: glyph outline flattener, sequencer plus point datapath
// One outline command is taken per item. A move or line item occupies the input through the
// idle and issue states and yields one point; a quadratic or cubic item occupies it through
// the idle state and SAMPLES issues (30 by default) and yields SAMPLES points, one per cycle
// while the output does not stall, which is the rate of the sample sequencer feeding the
// point pipeline. A point then passes the weighting, offset, scaling and rounding registers.
// While rsp_ready is low with a point waiting, the point pipeline and an issuing
// sequencer hold; an idle sequencer still takes one item, which then waits to issue.
// Settings writes are taken in every cycle and are meant only while no item is in flight.
`default_nettype none

module glyph_outline_flattener
   import gof_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [OP_W-1:0]           req_opcode,
   input  wire logic signed [COORD_W-1:0] req_ctrl1_x,
   input  wire logic signed [COORD_W-1:0] req_ctrl1_y,
   input  wire logic signed [COORD_W-1:0] req_ctrl2_x,
   input  wire logic signed [COORD_W-1:0] req_ctrl2_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [POINT_W-1:0]      rsp_point_x,
   output logic signed [POINT_W-1:0]      rsp_point_y,
   output logic                           rsp_strip_start,
   output logic                           rsp_last,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Settings port never stalls
   assign csr_ready = 1'b1;

   gof_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   gof_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_ctrl1_x     (req_ctrl1_x),
      .req_ctrl1_y     (req_ctrl1_y),
      .req_ctrl2_x     (req_ctrl2_x),
      .req_ctrl2_y     (req_ctrl2_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_strip_start (rsp_strip_start),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/gof_controller.sv =====
// Sequencer: takes items and issues one sample per cycle into the datapath while it advances
`default_nettype none

`include "glyph_outline_flattener_defines.svh"

module gof_controller
   import gof_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_opcode,
   input  wire dp_status_type   status,
   output ctrl_cmd_type         cmd
);

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             single;
   logic             final_sample;

   assign single       = (op_ff == OP_MOVE) || (op_ff == OP_LINE);
   assign final_sample = single || (cnt_ff == IDX_W'(SAMPLES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (status.advance && final_sample) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Capture the opcode and step the sample counter
   always_comb begin
      op_in  = op_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               cnt_in = '0;
            end
         end
         ST_ISSUE: begin
            if (status.advance && !final_sample) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: cnt_in = '0;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.load        = 1'b0;
      cmd.issue       = 1'b0;
      cmd.op          = op_ff;
      cmd.index       = cnt_ff;
      cmd.strip_start = (op_ff == OP_MOVE);
      cmd.last        = final_sample;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ISSUE: begin
            cmd.issue = status.advance;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_MOVE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   // An accepted item starts issuing from sample zero
   `GOF_ASSERT_NXT(a_accept_starts, clock, reset, req_valid && req_ready,
                   state_ff == ST_ISSUE && cnt_ff == '0)
   // The final sample of an item returns the sequencer to idle
   `GOF_ASSERT_NXT(a_last_ends, clock, reset, cmd.issue && cmd.last, state_ff == ST_IDLE)
   // The sample counter never runs past the curve
   `GOF_ASSERT_IMP(a_cnt_range, clock, reset, state_ff == ST_ISSUE,
                   {1'b0, cnt_ff} < (IDX_W + 1)'(SAMPLES))

endmodule

`default_nettype wire

// ===== rtl/gof_datapath.sv =====
// Datapath: operands, pen, settings and the four-stage point pipeline
`default_nettype none

`include "glyph_outline_flattener_defines.svh"

module gof_datapath
   import gof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire logic signed [COORD_W-1:0] req_ctrl1_x,
   input  wire logic signed [COORD_W-1:0] req_ctrl1_y,
   input  wire logic signed [COORD_W-1:0] req_ctrl2_x,
   input  wire logic signed [COORD_W-1:0] req_ctrl2_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [POINT_W-1:0]  rsp_point_x,
   output logic signed [POINT_W-1:0]  rsp_point_y,
   output logic                       rsp_strip_start,
   output logic                       rsp_last
);

   localparam int unsigned TERM_W  = WEIGHT_W + 1 + COORD_W;
   localparam int unsigned DIFF_W  = TERM_W + 2;
   localparam int unsigned SCALE_W = DIFF_W + RECIP_W + 1;
   localparam int unsigned SHIFT   = 24;
   localparam int unsigned RND_W   = SCALE_W - SHIFT;

   // Settings
   logic signed [COORD_W-1:0] bearing_ff, bearing_in;
   logic signed [COORD_W-1:0] descender_ff, descender_in;
   logic [RECIP_W-1:0]        recip_ff, recip_in;

   // Pen and item operands; slot 0 pen, 1 and 2 controls, 3 end
   logic signed [COORD_W-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [COORD_W-1:0] px_ff [4];
   logic signed [COORD_W-1:0] px_in [4];
   logic signed [COORD_W-1:0] py_ff [4];
   logic signed [COORD_W-1:0] py_in [4];

   // Pipeline
   logic                      advance;
   logic [WEIGHT_W-1:0]       weight [4];
   logic signed [TERM_W-1:0]  term_x_ff [4];
   logic signed [TERM_W-1:0]  term_x_in [4];
   logic signed [TERM_W-1:0]  term_y_ff [4];
   logic signed [TERM_W-1:0]  term_y_in [4];
   logic                      a_vld_ff, a_start_ff, a_last_ff;
   logic signed [DIFF_W-1:0]  diff_x_ff, diff_x_in, diff_y_ff, diff_y_in;
   logic                      b_vld_ff, b_start_ff, b_last_ff;
   logic signed [SCALE_W-1:0] scaled_x_ff, scaled_x_in, scaled_y_ff, scaled_y_in;
   logic                      c_vld_ff, c_start_ff, c_last_ff;
   logic signed [POINT_W-1:0] point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic                      rsp_valid_ff, rsp_start_ff, rsp_last_ff;

   // Round half away from zero, drop the Q40 fraction and clamp to Q3.16
   function automatic logic signed [POINT_W-1:0] round_sat(logic signed [SCALE_W-1:0] p);
      logic signed [SCALE_W-1:0] t;
      logic signed [RND_W-1:0]   r;
      logic                      neg;
      neg = p[SCALE_W-1];
      t   = p + $signed(SCALE_W'(1 << (SHIFT - 1))) - $signed(SCALE_W'(neg));
      r   = $signed(t[SCALE_W-1:SHIFT]);
      if (r[RND_W-1:POINT_W-1] == '0 || r[RND_W-1:POINT_W-1] == '1) begin
         return r[POINT_W-1:0];
      end else if (r[RND_W-1]) begin
         return {1'b1, {(POINT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POINT_W-1){1'b1}}};
      end
   endfunction

   // Move the whole pipeline unless a finished point is held
   assign advance        = !rsp_valid_ff || rsp_ready;
   assign status.advance = advance;

   // Settings writes
   always_comb begin
      bearing_in   = bearing_ff;
      descender_in = descender_ff;
      recip_in     = recip_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BEARING:   bearing_in   = csr_data[COORD_W-1:0];
            CSR_DESCENDER: descender_in = csr_data[COORD_W-1:0];
            CSR_RECIP:     recip_in     = csr_data[RECIP_W-1:0];
            default:       recip_in     = recip_ff;
         endcase
      end
   end

   // Latch operands and move the pen to the end point
   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      if (cmd.load) begin
         px_in[0] = pen_x_ff;
         py_in[0] = pen_y_ff;
         px_in[1] = req_ctrl1_x;
         py_in[1] = req_ctrl1_y;
         px_in[2] = req_ctrl2_x;
         py_in[2] = req_ctrl2_y;
         px_in[3] = req_end_x;
         py_in[3] = req_end_y;
         pen_x_in = req_end_x;
         pen_y_in = req_end_y;
      end
   end

   // Stage A: look up weights and form the weighted terms
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         case (cmd.op)
            OP_CUBIC: weight[k] = CUBIC_WEIGHTS[cmd.index][k];
            OP_QUAD:  weight[k] = QUAD_WEIGHTS[cmd.index][k];
            default:  weight[k] = (k == 3) ? WEIGHT_ONE : '0;
         endcase
         term_x_in[k] = $signed({1'b0, weight[k]}) * px_ff[k];
         term_y_in[k] = $signed({1'b0, weight[k]}) * py_ff[k];
      end
   end

   // Stage B: sum the terms and remove the offsets
   always_comb begin
      diff_x_in = DIFF_W'(term_x_ff[0]) + DIFF_W'(term_x_ff[1]) + DIFF_W'(term_x_ff[2])
                + DIFF_W'(term_x_ff[3])
                - $signed({{(DIFF_W - COORD_W - FRAC_W){bearing_ff[COORD_W-1]}},
                           bearing_ff, {FRAC_W{1'b0}}});
      diff_y_in = DIFF_W'(term_y_ff[0]) + DIFF_W'(term_y_ff[1]) + DIFF_W'(term_y_ff[2])
                + DIFF_W'(term_y_ff[3])
                - $signed({{(DIFF_W - COORD_W - FRAC_W){descender_ff[COORD_W-1]}},
                           descender_ff, {FRAC_W{1'b0}}});
   end

   // Stage C: scale by the em height reciprocal
   always_comb begin
      scaled_x_in = diff_x_ff * $signed({1'b0, recip_ff});
      scaled_y_in = diff_y_ff * $signed({1'b0, recip_ff});
   end

   // Stage D: round and clamp into the output register
   always_comb begin
      point_x_in = round_sat(scaled_x_ff);
      point_y_in = round_sat(scaled_y_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bearing_ff   <= '0;
         descender_ff <= '0;
         recip_ff     <= RECIP_RESET;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bearing_ff   <= bearing_in;
         descender_ff <= descender_in;
         recip_ff     <= recip_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         if (advance) begin
            a_vld_ff     <= cmd.issue;
            b_vld_ff     <= a_vld_ff;
            c_vld_ff     <= b_vld_ff;
            rsp_valid_ff <= c_vld_ff;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      if (advance) begin
         term_x_ff    <= term_x_in;
         term_y_ff    <= term_y_in;
         a_start_ff   <= cmd.strip_start;
         a_last_ff    <= cmd.last;
         diff_x_ff    <= diff_x_in;
         diff_y_ff    <= diff_y_in;
         b_start_ff   <= a_start_ff;
         b_last_ff    <= a_last_ff;
         scaled_x_ff  <= scaled_x_in;
         scaled_y_ff  <= scaled_y_in;
         c_start_ff   <= b_start_ff;
         c_last_ff    <= b_last_ff;
         point_x_ff   <= point_x_in;
         point_y_ff   <= point_y_in;
         rsp_start_ff <= c_start_ff;
         rsp_last_ff  <= c_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = point_x_ff;
   assign rsp_point_y     = point_y_ff;
   assign rsp_strip_start = rsp_start_ff;
   assign rsp_last        = rsp_last_ff;

   // A held point freezes every stage
   `GOF_ASSERT_NXT(a_stall_freezes, clock, reset, !advance,
                   $stable({a_vld_ff, b_vld_ff, c_vld_ff, rsp_valid_ff}))
   // Loading an item moves the pen to its end point
   `GOF_ASSERT_NXT(a_pen_follows, clock, reset, cmd.load,
                   pen_x_ff == $past(req_end_x) && pen_y_ff == $past(req_end_y))

endmodule

`default_nettype wire

// ===== verif/glyph_outline_flattener_tb.sv =====
// Testbench for the glyph outline flattener: directed and random outlines checked point by point
`timescale 1ns / 1ps

module glyph_outline_flattener_tb
   import gof_pkg::*;
();

   // Register index past the end of the map; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned PRESSURE_HOLD = 300;
   localparam int unsigned RANDOM_ITEMS  = 340;

   typedef struct packed {
      logic signed [POINT_W-1:0] px;
      logic signed [POINT_W-1:0] py;
      logic                      strip;
      logic                      is_last;
   } flat_point_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_opcode;
   logic signed [COORD_W-1:0] req_ctrl1_x;
   logic signed [COORD_W-1:0] req_ctrl1_y;
   logic signed [COORD_W-1:0] req_ctrl2_x;
   logic signed [COORD_W-1:0] req_ctrl2_y;
   logic signed [COORD_W-1:0] req_end_x;
   logic signed [COORD_W-1:0] req_end_y;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [POINT_W-1:0] rsp_point_x;
   logic signed [POINT_W-1:0] rsp_point_y;
   logic                      rsp_strip_start;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   // Predictor copies of the pen and the normalization registers
   logic signed [COORD_W-1:0] pen_x_now;
   logic signed [COORD_W-1:0] pen_y_now;
   logic signed [COORD_W-1:0] bearing_now;
   logic signed [COORD_W-1:0] descender_now;
   logic [RECIP_W-1:0]        recip_now;

   flat_point_type expected_points[$];
   flat_point_type head_point;

   int unsigned fail_count;
   int unsigned items_sent;
   int unsigned points_checked;
   int unsigned settings_written;
   bit          req_gaps_on;
   bit          rsp_gaps_on;
   bit          hold_request;
   int unsigned stall_left;

   glyph_outline_flattener u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_ctrl1_x     (req_ctrl1_x),
      .req_ctrl1_y     (req_ctrl1_y),
      .req_ctrl2_x     (req_ctrl2_x),
      .req_ctrl2_y     (req_ctrl2_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_strip_start (rsp_strip_start),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Overall time limit, far above the slowest legal run
   initial begin
      #5000000;
      $error("run timed out with %0d points still expected", expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 93) begin
         return $urandom_range(4, 9);
      end
      return $urandom_range(15, 40);
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return COORD_W'($urandom_range(0, 4095) - 2048);
         default: return COORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Rounded Bernstein weight in Q1.16 for one term at one sample position
   function automatic longint unsigned bernstein_q16(int unsigned degree, int unsigned term,
                                                     int unsigned sample_idx);
      longint unsigned span;
      longint unsigned num;
      longint unsigned den;
      span = longint'(SAMPLES - 1);
      num  = 65536;
      den  = 1;
      if (term != 0 && term != degree) begin
         num = num * degree;
      end
      for (int unsigned j = 0; j < term; j++) begin
         num = num * sample_idx;
      end
      for (int unsigned j = 0; j < degree - term; j++) begin
         num = num * (span - sample_idx);
      end
      for (int unsigned j = 0; j < degree; j++) begin
         den = den * span;
      end
      return (num + den / 2) / den;
   endfunction

   // Offset, scale by the reciprocal, round half away from zero, saturate to Q3.16
   function automatic logic signed [POINT_W-1:0] to_unit_space(longint q16, longint offset);
      longint          diff;
      longint          prod;
      longint unsigned mag;
      longint unsigned rnd;
      longint          v;
      diff = q16 - offset * 65536;
      prod = diff * longint'(recip_now);
      mag  = (prod < 0) ? longint'(-prod) : prod;
      rnd  = (mag + 64'd8388608) >> 24;
      if (prod < 0) begin
         v = (rnd > 524288) ? -524288 : -longint'(rnd);
      end else begin
         v = (rnd > 524287) ? 524287 : longint'(rnd);
      end
      return v[POINT_W-1:0];
   endfunction

   function automatic void push_point(longint qx, longint qy, logic strip, logic is_last);
      flat_point_type pt;
      pt.px      = to_unit_space(qx, longint'(bearing_now));
      pt.py      = to_unit_space(qy, longint'(descender_now));
      pt.strip   = strip;
      pt.is_last = is_last;
      expected_points.insert(expected_points.size(), pt);
   endfunction

   // Expected points for one accepted command; advances the pen
   function automatic void predict_outline(logic [OP_W-1:0] op,
                                           logic signed [COORD_W-1:0] c1x, c1y, c2x, c2y,
                                           logic signed [COORD_W-1:0] ex, ey);
      longint      ctl_x[4];
      longint      ctl_y[4];
      longint      sx;
      longint      sy;
      longint      w;
      int unsigned degree;
      if (op == OP_MOVE || op == OP_LINE) begin
         push_point(longint'(ex) * 65536, longint'(ey) * 65536, op == OP_MOVE, 1'b1);
      end else begin
         ctl_x[0] = longint'(pen_x_now);
         ctl_y[0] = longint'(pen_y_now);
         ctl_x[1] = longint'(c1x);
         ctl_y[1] = longint'(c1y);
         if (op == OP_QUAD) begin
            degree   = 2;
            ctl_x[2] = longint'(ex);
            ctl_y[2] = longint'(ey);
         end else begin
            degree   = 3;
            ctl_x[2] = longint'(c2x);
            ctl_y[2] = longint'(c2y);
            ctl_x[3] = longint'(ex);
            ctl_y[3] = longint'(ey);
         end
         for (int unsigned i = 0; i < SAMPLES; i++) begin
            sx = 0;
            sy = 0;
            for (int unsigned k = 0; k <= degree; k++) begin
               w  = longint'(bernstein_q16(degree, k, i));
               sx = sx + w * ctl_x[k];
               sy = sy + w * ctl_y[k];
            end
            push_point(sx, sy, 1'b0, i == SAMPLES - 1);
         end
      end
      pen_x_now = ex;
      pen_y_now = ey;
   endfunction

   // Offer one command after an optional gap, hold it until taken, then predict
   task automatic send_command(logic [OP_W-1:0] op,
                               logic signed [COORD_W-1:0] c1x, c1y, c2x, c2y,
                               logic signed [COORD_W-1:0] ex, ey);
      int unsigned gap;
      gap = (req_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode  = op;
      req_ctrl1_x = c1x;
      req_ctrl1_y = c1y;
      req_ctrl2_x = c2x;
      req_ctrl2_y = c2y;
      req_end_x   = ex;
      req_end_y   = ey;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_outline(op, c1x, c1y, c2x, c2y, ex, ey);
      items_sent++;
   endtask

   task automatic send_random(logic [OP_W-1:0] op);
      send_command(op, random_coord(), random_coord(), random_coord(), random_coord(),
                   random_coord(), random_coord());
   endtask

   // Drop valid, wait for every expected point, then let the pipeline settle
   task automatic finish_phase();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BEARING:   bearing_now   = data[COORD_W-1:0];
         CSR_DESCENDER: descender_now = data[COORD_W-1:0];
         CSR_RECIP:     recip_now     = data;
         default: ;
      endcase
      settings_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offsets carry random upper bits, which the block must ignore
   task automatic apply_settings(logic signed [COORD_W-1:0] bearing,
                                 logic signed [COORD_W-1:0] descender,
                                 logic [RECIP_W-1:0] recip);
      write_setting(CSR_BEARING, {8'($urandom_range(0, 255)), bearing});
      write_setting(CSR_DESCENDER, {8'($urandom_range(0, 255)), descender});
      write_setting(CSR_RECIP, recip);
   endtask

   task automatic randomize_settings();
      logic signed [COORD_W-1:0] descender;
      logic [RECIP_W-1:0]        recip;
      descender = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom_range(0, 65535))
                                              : COORD_W'(-$urandom_range(0, 32768));
      recip = ($urandom_range(0, 4) == 0) ? RECIP_W'($urandom_range(1, 16777215))
                                          : RECIP_W'($urandom_range(2000, 40000));
      apply_settings(COORD_W'($urandom_range(0, 65535)), descender, recip);
   endtask

   // Reset values; curves and lines before any move, field extremes, ignored fields
   task automatic test_directed_commands();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_command(OP_QUAD, 16'sd100, -16'sd200, 16'sd0, 16'sd0, 16'sd300, 16'sd400);
      send_command(OP_LINE, random_coord(), random_coord(), random_coord(), random_coord(),
                   -16'sd1000, 16'sd2000);
      send_command(OP_CUBIC, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0);
      send_command(OP_MOVE, random_coord(), random_coord(), random_coord(), random_coord(),
                   16'sh7FFF, 16'sh7FFF);
      send_command(OP_MOVE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
      send_command(OP_LINE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000);
      send_command(OP_LINE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF);
      send_command(OP_QUAD, 16'sh7FFF, 16'sh8000, random_coord(), random_coord(),
                   16'sh8000, 16'sh7FFF);
      send_command(OP_CUBIC, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                   16'sh8000, 16'sh7FFF);
      send_command(OP_MOVE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_command(OP_CUBIC, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_command(OP_LINE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'sd0, 16'sd0);
      send_command(OP_QUAD, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
                   16'shFFFF, 16'shFFFF);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_random(OP_MOVE);
      send_random(OP_QUAD);
      send_random(OP_CUBIC);
      send_random(OP_LINE);
      finish_phase();
   endtask

   // Register extremes: full-scale saturation, tiny scale, zero scale, unmapped index
   task automatic test_setting_extremes();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      for (int unsigned s = 0; s < 5; s++) begin
         case (s)
            0: apply_settings(16'sh8000, 16'sd0, 24'hFFFFFF);
            1: apply_settings(16'sh7FFF, 16'sh8000, 24'd1);
            2: apply_settings(16'sd0, 16'sh7FFF, 24'd0);
            3: begin
               apply_settings(16'sd123, -16'sd512, 24'd8192);
               write_setting(CSR_UNMAPPED, 24'($urandom_range(0, 16777215)));
            end
            default: apply_settings(16'sd0, 16'sd0, RECIP_RESET);
         endcase
         send_random(OP_MOVE);
         for (int unsigned n = 0; n < 7; n++) begin
            send_random(OP_W'($urandom_range(0, 3)));
         end
         finish_phase();
      end
   endtask

   // Well-formed outlines with random content, some stray commands mixed in
   task automatic test_random_outlines();
      int unsigned target;
      int unsigned phase_end;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         randomize_settings();
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         phase_end   = items_sent + 30;
         while (items_sent < phase_end && items_sent < target) begin
            if ($urandom_range(0, 99) < 15) begin
               send_random(OP_W'($urandom_range(0, 3)));
            end else begin
               send_random(OP_MOVE);
               repeat ($urandom_range(2, 8)) send_random(OP_W'($urandom_range(1, 3)));
            end
         end
         finish_phase();
      end
   endtask

   // Hold the output off for a long stretch so the pipeline fills and stalls the input
   task automatic test_output_backpressure();
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = 1'b1;
      send_random(OP_MOVE);
      repeat (11) send_random(OP_W'($urandom_range(1, 3)));
      finish_phase();
   endtask

   // Output ready: random stalls, plus the long hold on request
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = PRESSURE_HOLD;
         end
         if (stall_left == 0 && rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Compare each taken point against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("point with nothing expected: x %0d y %0d", rsp_point_x, rsp_point_y);
            fail_count++;
         end else begin
            head_point = expected_points.pop_front();
            points_checked++;
            if (rsp_point_x !== head_point.px) begin
               $error("point_x expected %0d got %0d", head_point.px, rsp_point_x);
               fail_count++;
            end
            if (rsp_point_y !== head_point.py) begin
               $error("point_y expected %0d got %0d", head_point.py, rsp_point_y);
               fail_count++;
            end
            if (rsp_strip_start !== head_point.strip) begin
               $error("strip_start expected %0b got %0b", head_point.strip, rsp_strip_start);
               fail_count++;
            end
            if (rsp_last !== head_point.is_last) begin
               $error("last expected %0b got %0b", head_point.is_last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_MOVE;
      req_ctrl1_x      = '0;
      req_ctrl1_y      = '0;
      req_ctrl2_x      = '0;
      req_ctrl2_y      = '0;
      req_end_x        = '0;
      req_end_y        = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_BEARING;
      csr_data         = '0;
      pen_x_now        = '0;
      pen_y_now        = '0;
      bearing_now      = '0;
      descender_now    = '0;
      recip_now        = RECIP_RESET;
      fail_count       = 0;
      items_sent       = 0;
      points_checked   = 0;
      settings_written = 0;
      req_gaps_on      = 1'b0;
      rsp_gaps_on      = 1'b0;
      hold_request     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_commands();
      test_setting_extremes();
      test_output_backpressure();
      test_random_outlines();

      $display("Flattened %0d outline commands into %0d checked points over %0d register writes",
               items_sent, points_checked, settings_written);
      $display("Included saturation, zero scale, an unmapped index and a long output hold");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
